[rtl/core/frsd_pkg.sv]
`default_nettype none
package frsd_pkg;

    localparam int TPS_W  = 32;
    localparam int Q_BITS = 16;
    localparam int NUM_W  = 39;
    localparam int DEN_W  = 47;
    localparam int DIGITS = 4;
    localparam int BCD_W  = 4 * DIGITS;

    localparam logic [TPS_W-1:0] TPS_RESET = 32'd1000000;
    localparam logic [6:0]       RATE_SCALE = 7'd100;
    localparam logic [7:0]       SEG_DOT = 8'h80;

    localparam logic REG_TPS = 1'b0;

    typedef struct packed {
        logic             valid;
        logic             ovf;
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [BCD_W-1:0] bcd;
    } cell_t;

    typedef struct packed {
        logic        valid;
        logic [23:0] low_word;
        logic [7:0]  high_word;
        logic        ovf;
    } seg_word_t;

endpackage
`default_nettype wire

[rtl/core/frame_rate_seven_segment_display_unit.sv]
// channel   direction  payload                                         handshake
// s_        in         start_time[31:0], end_time[31:0]                s_valid / s_ready
// m_        out        low_digits_word[23:0], high_digit_word[7:0],    m_valid / m_ready
//                      rate_overflow
// apb       in/out     ticks_per_second at byte address 0              psel / penable / pready
//
// One request per cycle while s_ready is high; a result passes, in order, through
// two front stages (subtract and scale, saturation test) then sixteen division cells,
// one quotient bit and one BCD shift each, then the output register.
// A skid register behind the output register takes one result while m_ready is low;
// the pipeline and s_ready stall only while the skid register is full.
// Synchronous active-low reset empties the pipeline and loads ticks_per_second = 1000000.
`default_nettype none
module frame_rate_seven_segment_display_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_start_time,
    input  wire logic [31:0] s_end_time,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [23:0]      m_low_digits_word,
    output logic [7:0]       m_high_digit_word,
    output logic             m_rate_overflow,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [31:0]          tps_reg;
    logic                 en;
    logic                 m_free;
    frsd_pkg::cell_t      chain [0:frsd_pkg::Q_BITS];
    frsd_pkg::seg_word_t  tail;
    frsd_pkg::seg_word_t  out_reg;
    frsd_pkg::seg_word_t  skid_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == frsd_pkg::REG_TPS) ? tps_reg : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg <= frsd_pkg::TPS_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == frsd_pkg::REG_TPS) begin
            tps_reg <= pwdata;
        end
    end

    assign en      = !skid_reg.valid;
    assign s_ready = en;
    assign m_free  = !out_reg.valid || m_ready;

    frsd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .s_valid      (s_valid),
        .s_start_time (s_start_time),
        .s_end_time   (s_end_time),
        .tps          (tps_reg),
        .cell_o       (chain[0])
    );

    for (genvar k = 0; k < frsd_pkg::Q_BITS; k++) begin : g_cell
        frsd_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .cell_i  (chain[k]),
            .cell_o  (chain[k+1])
        );
    end

    frsd_seg u_seg (
        .cell_i (chain[frsd_pkg::Q_BITS]),
        .word_o (tail)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid  <= 1'b0;
            skid_reg.valid <= 1'b0;
        end else if (skid_reg.valid) begin
            if (m_free) begin
                out_reg        <= skid_reg;
                skid_reg.valid <= 1'b0;
            end
        end else if (m_free) begin
            out_reg <= tail;
        end else if (tail.valid) begin
            skid_reg <= tail;
        end
    end

    assign m_valid           = out_reg.valid;
    assign m_low_digits_word = out_reg.low_word;
    assign m_high_digit_word = out_reg.high_word;
    assign m_rate_overflow   = out_reg.ovf;

endmodule
`default_nettype wire

[rtl/core/frsd_front.sv]
`default_nettype none
module frsd_front (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire logic                     s_valid,
    input  wire logic [31:0]              s_start_time,
    input  wire logic [31:0]              s_end_time,
    input  wire logic [31:0]              tps,
    output frsd_pkg::cell_t               cell_o
);

    logic                        a_valid_reg;
    logic [31:0]                 delta_reg;
    logic [frsd_pkg::NUM_W-1:0]  num_reg;
    logic [31:0]                 delta_next;
    logic [frsd_pkg::NUM_W-1:0]  num_next;
    frsd_pkg::cell_t             b_reg;
    frsd_pkg::cell_t             b_next;

    always_comb begin
        delta_next = s_end_time - s_start_time;
        num_next   = {7'b0, tps} * {32'b0, frsd_pkg::RATE_SCALE};
    end

    // saturate when the quotient would need a seventeenth bit, zero delta included
    always_comb begin
        b_next.valid = a_valid_reg;
        b_next.ovf   = {9'b0, num_reg} >= {delta_reg, 16'b0};
        b_next.rem   = num_reg;
        b_next.den   = {delta_reg, 15'b0};
        b_next.bcd   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            delta_reg <= delta_next;
            num_reg   <= num_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg.valid <= 1'b0;
        end else if (en) begin
            b_reg <= b_next;
        end
    end

    assign cell_o = b_reg;

endmodule
`default_nettype wire

[rtl/core/frsd_cell.sv]
`default_nettype none
module frsd_cell (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire frsd_pkg::cell_t  cell_i,
    output frsd_pkg::cell_t       cell_o
);

    frsd_pkg::cell_t               cell_reg;
    frsd_pkg::cell_t               cell_next;
    logic                          ge;
    logic                          qbit;
    logic [frsd_pkg::BCD_W-1:0]    adj;
    logic [3:0]                    d;

    always_comb begin
        ge   = {8'b0, cell_i.rem} >= cell_i.den;
        qbit = cell_i.ovf | ge;
        adj  = '0;
        for (int i = 0; i < frsd_pkg::DIGITS; i++) begin
            d = cell_i.bcd[4*i +: 4];
            adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
        cell_next     = cell_i;
        cell_next.den = cell_i.den >> 1;
        if (ge && !cell_i.ovf) begin
            cell_next.rem = cell_i.rem - cell_i.den[frsd_pkg::NUM_W-1:0];
        end
        // drop the ten-thousands carry
        cell_next.bcd = {adj[frsd_pkg::BCD_W-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_o = cell_reg;

endmodule
`default_nettype wire

[rtl/core/frsd_seg.sv]
`default_nettype none
module frsd_seg (
    input  wire frsd_pkg::cell_t  cell_i,
    output frsd_pkg::seg_word_t   word_o
);

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] s;
        unique case (digit)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = 8'hFF;
        endcase
        return s;
    endfunction

    logic [7:0] s0, s1, s2, s3;

    always_comb begin
        s0 = seg_of(cell_i.bcd[3:0])   | frsd_pkg::SEG_DOT;
        s1 = seg_of(cell_i.bcd[7:4])   | frsd_pkg::SEG_DOT;
        s2 = seg_of(cell_i.bcd[11:8])  & ~frsd_pkg::SEG_DOT;
        s3 = seg_of(cell_i.bcd[15:12]) | frsd_pkg::SEG_DOT;
        word_o.valid     = cell_i.valid;
        word_o.low_word  = {s2, s1, s0};
        word_o.high_word = s3;
        word_o.ovf       = cell_i.ovf;
    end

endmodule
`default_nettype wire

[rtl/core/frsd_check.sv]
`default_nettype none
module frsd_check (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [23:0] m_low_digits_word,
    input wire logic [7:0]  m_high_digit_word,
    input wire logic        m_rate_overflow
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_low_digits_word) && $stable(m_high_digit_word)
            && $stable(m_rate_overflow))
        else $error("stalled result changed");

    a_dots: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_low_digits_word[23] && m_low_digits_word[15]
            && m_low_digits_word[7] && m_high_digit_word[7])
        else $error("decimal point misplaced");

    a_saturate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rate_overflow |-> m_high_digit_word == 8'h92
            && m_low_digits_word == 24'h12B092)
        else $error("saturated rate not shown as 5535");

endmodule

bind frame_rate_seven_segment_display_unit frsd_check u_frsd_check (.*);
`default_nettype wire
